### src/hlc_pkg.sv
// Package: shared constants and types of the homogeneous line clipper.
`timescale 1ns / 1ps
package hlc_pkg;

  localparam int CoordWidthDef = 32;
  localparam int NumPlanes     = 6;

  typedef struct packed {
    logic valid;
    logic keep;
  } hlc_ctl_t;

  typedef enum logic [1:0] {
    CLIP_NONE = 2'b00,
    CLIP_A    = 2'b01,
    CLIP_B    = 2'b10
  } hlc_clip_e;

endpackage

### src/hlc_in_if.sv
// Interfaces: segment input channel and clipped segment output channel.
`timescale 1ns / 1ps
interface hlc_in_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] start_z;
  logic [W-1:0] start_w;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;
  logic [W-1:0] end_z;
  logic [W-1:0] end_w;

  modport source (output valid, start_x, start_y, start_z, start_w,
                  end_x, end_y, end_z, end_w, input ready);
  modport sink (input valid, start_x, start_y, start_z, start_w,
                end_x, end_y, end_z, end_w, output ready);
endinterface

interface hlc_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic         visible;
  logic [W-1:0] out_start_x;
  logic [W-1:0] out_start_y;
  logic [W-1:0] out_start_z;
  logic [W-1:0] out_start_w;
  logic [W-1:0] out_end_x;
  logic [W-1:0] out_end_y;
  logic [W-1:0] out_end_z;
  logic [W-1:0] out_end_w;

  modport source (output valid, visible, out_start_x, out_start_y, out_start_z,
                  out_start_w, out_end_x, out_end_y, out_end_z, out_end_w,
                  input ready);
  modport sink (input valid, visible, out_start_x, out_start_y, out_start_z,
                out_start_w, out_end_x, out_end_y, out_end_z, out_end_w,
                output ready);
endinterface

### src/hlc_plane.sv
// One clip plane: distances, exact interpolation with a pipelined divider.
`timescale 1ns / 1ps
module hlc_plane #(
  parameter int W     = 32,
  parameter int PLANE = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  hlc_pkg::hlc_ctl_t     ctl_i,
  input  logic [3:0][W-1:0]     a_i,
  input  logic [3:0][W-1:0]     b_i,
  output hlc_pkg::hlc_ctl_t     ctl_o,
  output logic [3:0][W-1:0]     a_o,
  output logic [3:0][W-1:0]     b_o
);
  import hlc_pkg::*;

  localparam int  AX = PLANE / 2;
  localparam bit  POS = (PLANE % 2) == 1;
  localparam int  NS = W + 2;

  // stage 1: plane distances
  logic signed [W:0] aw, ax, bw, bx, da_d, db_d;
  hlc_ctl_t          ctl1_d, ctl1_q;
  hlc_clip_e         mode1_d, mode1_q;
  logic [3:0][W-1:0] a1_q, b1_q;
  logic signed [W:0] da1_q, db1_q;

  always_comb begin
    aw = $signed({a_i[3][W-1], a_i[3]});
    ax = $signed({a_i[AX][W-1], a_i[AX]});
    bw = $signed({b_i[3][W-1], b_i[3]});
    bx = $signed({b_i[AX][W-1], b_i[AX]});
    da_d = POS ? aw + ax : aw - ax;
    db_d = POS ? bw + bx : bw - bx;
    ctl1_d.valid = ctl_i.valid;
    ctl1_d.keep  = ctl_i.keep & ~(da_d[W] & db_d[W]);
    if (da_d[W] != db_d[W]) begin
      mode1_d = da_d[W] ? CLIP_A : CLIP_B;
    end else begin
      mode1_d = CLIP_NONE;
    end
  end

  // stage 2: differences and magnitudes
  logic signed [W+1:0]     den;
  logic [3:0][W:0]         diff;
  logic [W:0]              mda_d;
  logic [3:0][W:0]         mdiff_d;
  logic [W+1:0]            mden_d;
  logic [3:0]              neg_d;
  hlc_ctl_t                ctl2_q;
  hlc_clip_e               mode2_q;
  logic [3:0][W-1:0]       a2_q, b2_q;
  logic [W:0]              mda2_q;
  logic [3:0][W:0]         mdiff2_q;
  logic [W+1:0]            mden2_q;
  logic [3:0]              neg2_q;

  always_comb begin
    den    = $signed({da1_q[W], da1_q}) - $signed({db1_q[W], db1_q});
    mda_d  = da1_q[W] ? (W+1)'(0) - da1_q : da1_q;
    mden_d = den[W+1] ? (W+2)'(0) - den : den;
    for (int i = 0; i < 4; i++) begin
      diff[i]    = {b1_q[i][W-1], b1_q[i]} - {a1_q[i][W-1], a1_q[i]};
      mdiff_d[i] = diff[i][W] ? (W+1)'(0) - diff[i] : diff[i];
      neg_d[i]   = da1_q[W] ^ diff[i][W] ^ den[W+1];
    end
  end

  // divider pipeline, entry 0 holds the products
  hlc_ctl_t          dctl_q  [NS];
  hlc_clip_e         dmode_q [NS];
  logic [3:0][W-1:0] dA_q    [NS];
  logic [3:0][W-1:0] dB_q    [NS];
  logic [3:0]        dneg_q  [NS];
  logic [W+1:0]      dden_q  [NS];
  logic [3:0][W+1:0] drem_q  [NS];
  logic [3:0][W:0]   dlow_q  [NS];
  logic [2*W+1:0]    prod [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = (2*W+2)'(mda2_q) * (2*W+2)'(mdiff2_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q  <= mode1_d;
      a1_q     <= a_i;
      b1_q     <= b_i;
      da1_q    <= da_d;
      db1_q    <= db_d;
      mode2_q  <= mode1_q;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      mda2_q   <= mda_d;
      mdiff2_q <= mdiff_d;
      mden2_q  <= mden_d;
      neg2_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dctl_q[0] <= '0;
    end else if (en_i) begin
      dctl_q[0] <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmode_q[0] <= mode2_q;
      dA_q[0]    <= a2_q;
      dB_q[0]    <= b2_q;
      dneg_q[0]  <= neg2_q;
      dden_q[0]  <= mden2_q;
      for (int i = 0; i < 4; i++) begin
        drem_q[0][i] <= {1'b0, prod[i][2*W+1:W+1]};
        dlow_q[0][i] <= prod[i][W:0];
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_div
    logic [3:0][W+2:0] t;
    logic [3:0]        ge;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t[i]  = {drem_q[s-1][i], dlow_q[s-1][i][W]};
        ge[i] = t[i] >= {1'b0, dden_q[s-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dctl_q[s] <= '0;
      end else if (en_i) begin
        dctl_q[s] <= dctl_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmode_q[s] <= dmode_q[s-1];
        dA_q[s]    <= dA_q[s-1];
        dB_q[s]    <= dB_q[s-1];
        dneg_q[s]  <= dneg_q[s-1];
        dden_q[s]  <= dden_q[s-1];
        for (int i = 0; i < 4; i++) begin
          drem_q[s][i] <= ge[i] ? (W+2)'(t[i] - {1'b0, dden_q[s-1]}) : t[i][W+1:0];
          dlow_q[s][i] <= {dlow_q[s-1][i][W-1:0], ge[i]};
        end
      end
    end
  end

  // final stage: apply offset, saturate, replace the outside endpoint
  logic signed [W+2:0] off, sum;
  logic [3:0][W-1:0]   p;
  logic [3:0][W-1:0]   a_d, b_d;
  hlc_ctl_t            ctlf_q;
  logic [3:0][W-1:0]   af_q, bf_q;

  always_comb begin
    off = '0;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      off = dneg_q[NS-1][i] ? $signed((W+3)'(0) - {2'b00, dlow_q[NS-1][i]})
                            : $signed({2'b00, dlow_q[NS-1][i]});
      sum = $signed({{3{dA_q[NS-1][i][W-1]}}, dA_q[NS-1][i]}) + off;
      if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
        p[i] = sum[W-1:0];
      end else begin
        p[i] = {sum[W+2], {(W-1){~sum[W+2]}}};
      end
    end
    a_d = dA_q[NS-1];
    b_d = dB_q[NS-1];
    unique case (dmode_q[NS-1])
      CLIP_A:  a_d = p;
      CLIP_B:  b_d = p;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctlf_q <= '0;
    end else if (en_i) begin
      ctlf_q <= dctl_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      af_q <= a_d;
      bf_q <= b_d;
    end
  end

  assign ctl_o = ctlf_q;
  assign a_o   = af_q;
  assign b_o   = bf_q;

endmodule

### src/homogeneous_line_clipper_top.sv
// Top level: six-plane homogeneous line clipper with output register.
//
//   channel  dir  words
//   in_i     in   segment: start_x..w, end_x..w
//   out_o    out  visible, out_start_x..w, out_end_x..w
//
// One word per cycle sustained while out_o is not stalled; each plane interpolates with a
// divider that resolves one quotient bit per stage.
// Reset clears all valid bits; coordinate registers are not reset.
// A stall on out_o freezes every stage at once; nothing is lost or repeated.
`timescale 1ns / 1ps
module homogeneous_line_clipper_top #(
  parameter int COORD_WIDTH = hlc_pkg::CoordWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlc_in_if.sink    in_i,
  hlc_out_if.source out_o
);
  import hlc_pkg::*;

  localparam int W = COORD_WIDTH;

  logic              en;
  hlc_ctl_t          ctl [NumPlanes+1];
  logic [3:0][W-1:0] pa  [NumPlanes+1];
  logic [3:0][W-1:0] pb  [NumPlanes+1];

  logic              out_valid_q;
  logic              vis_q;
  logic [3:0][W-1:0] oa_q, ob_q;
  logic              vis_d;

  assign en        = ~out_valid_q | out_o.ready;
  assign in_i.ready = en;

  assign ctl[0].valid = in_i.valid;
  assign ctl[0].keep  = 1'b1;
  assign pa[0] = {in_i.start_w, in_i.start_z, in_i.start_y, in_i.start_x};
  assign pb[0] = {in_i.end_w, in_i.end_z, in_i.end_y, in_i.end_x};

  for (genvar k = 0; k < NumPlanes; k++) begin : g_plane
    hlc_plane #(
      .W     (W),
      .PLANE (k)
    ) u_plane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[k]),
      .a_i    (pa[k]),
      .b_i    (pb[k]),
      .ctl_o  (ctl[k+1]),
      .a_o    (pa[k+1]),
      .b_o    (pb[k+1])
    );
  end

  assign vis_d = ctl[NumPlanes].keep
               & ~pa[NumPlanes][3][W-1] & (pa[NumPlanes][3] != '0)
               & ~pb[NumPlanes][3][W-1] & (pb[NumPlanes][3] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl[NumPlanes].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= vis_d;
      oa_q  <= vis_d ? pa[NumPlanes] : '0;
      ob_q  <= vis_d ? pb[NumPlanes] : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.visible     = vis_q;
  assign out_o.out_start_x = oa_q[0];
  assign out_o.out_start_y = oa_q[1];
  assign out_o.out_start_z = oa_q[2];
  assign out_o.out_start_w = oa_q[3];
  assign out_o.out_end_x   = ob_q[0];
  assign out_o.out_end_y   = ob_q[1];
  assign out_o.out_end_z   = ob_q[2];
  assign out_o.out_end_w   = ob_q[3];

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !vis_q |-> oa_q == '0 && ob_q == '0)
    else $error("hidden segment carries nonzero coordinates");

  a_visible_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vis_q |-> !oa_q[3][W-1] && oa_q[3] != '0 &&
                             !ob_q[3][W-1] && ob_q[3] != '0)
    else $error("visible segment with non-positive w");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> out_valid_q && !out_o.ready)
    else $error("pipeline stalled without a waiting word");

endmodule
